### sv/pgb3d_pkg.sv
package pgb3d_pkg;

    localparam int DEF_MAX_SIZE = 32;

    localparam int SIZE_W   = 6;
    localparam int COORD_W  = 5;
    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    // 16x17 signed product, then room for 27 terms.
    localparam int PROD_W = 33;
    localparam int ACC_W  = 38;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_U        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_V        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_W        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CENTER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_FACE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_EDGE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CORNER = 3'd6;

    localparam logic [SIZE_W-1:0]   RST_SIZE          = 6'd32;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CENTER = 16'd13074;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_FACE   = 16'd7930;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_EDGE   = 16'd4810;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT_CORNER = 16'd2917;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Neighbor offsets are coded 0 for -1, 1 for none, 2 for +1.
    localparam logic [1:0] OFS_MINUS = 2'd0;
    localparam logic [1:0] OFS_NONE  = 2'd1;
    localparam logic [1:0] OFS_PLUS  = 2'd2;

    localparam logic [1:0] CLS_CENTER = 2'd0;
    localparam logic [1:0] CLS_FACE   = 2'd1;
    localparam logic [1:0] CLS_EDGE   = 2'd2;
    localparam logic [1:0] CLS_CORNER = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MOD,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Periodic neighbor of c (c < n) along one axis.
    function automatic logic [SIZE_W-1:0] wrap_step(
        input logic [SIZE_W-1:0] c,
        input logic [1:0]        ofs,
        input logic [SIZE_W-1:0] n
    );
        logic [SIZE_W-1:0] res;
        res = c;
        if (ofs == OFS_MINUS) begin
            res = (c == '0) ? n - 6'd1 : c - 6'd1;
        end else if (ofs == OFS_PLUS) begin
            res = (c + 6'd1 == n) ? '0 : c + 6'd1;
        end
        return res;
    endfunction

endpackage

### sv/periodic_gaussian_blur_3d.sv
// Write beat: the sample is stored after the bit-serial coordinate wrap, then the block is ready again.
// Read beat: bit-serial coordinate wrap, 27 voxel reads with one multiply-accumulate
// each, a pipeline drain (memory read, product, accumulate registers) and a final
// step to round and saturate; a new request is taken only once the result is loaded.
// A result that finds the output register full waits in the accumulator, stalling input.
// Synchronous active-low reset restores the size and weight registers, not the voxels.
module periodic_gaussian_blur_3d
    import pgb3d_pkg::*;
#(
    parameter int MAX_SIZE = DEF_MAX_SIZE
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_kind,
    input  logic [COORD_W-1:0]           i_coord_u,
    input  logic [COORD_W-1:0]           i_coord_v,
    input  logic [COORD_W-1:0]           i_coord_w,
    input  logic signed [SAMPLE_W-1:0]   i_sample,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [SAMPLE_W-1:0]   o_smoothed,
    output logic                         o_saturated
);

    localparam int DEPTH = MAX_SIZE * MAX_SIZE * MAX_SIZE;
    localparam int AW    = $clog2(DEPTH);

    t_state r_state, n_state;

    logic [SIZE_W-1:0]   r_size_u, r_size_v, r_size_w;
    logic [WEIGHT_W-1:0] r_wt_center, r_wt_face, r_wt_edge, r_wt_corner;

    logic                        r_kind;
    logic [COORD_W-1:0]          r_cu, r_cv, r_cw;
    logic signed [SAMPLE_W-1:0]  r_sample;
    logic [2:0]                  r_bit, n_bit;
    logic [SIZE_W-1:0]           r_ru, r_rv, r_rw, n_ru, n_rv, n_rw;
    logic [1:0]                  r_du, r_dv, r_dw, n_du, n_dv, n_dw;

    logic signed [SAMPLE_W-1:0]  mem [DEPTH];
    logic signed [SAMPLE_W-1:0]  r_mem_q;
    logic                        r_p1_vld;
    logic [WEIGHT_W-1:0]         r_p1_wt, n_p1_wt;
    logic signed [PROD_W-1:0]    r_prod;
    logic                        r_p2_vld;
    logic signed [ACC_W-1:0]     r_acc, n_acc;

    logic                        r_out_vld, n_out_vld;
    logic signed [SAMPLE_W-1:0]  r_smoothed, n_smoothed;
    logic                        r_sat, n_sat;

    logic [SIZE_W-1:0] eff_u, eff_v, eff_w;
    logic              accept;
    logic              rd_en, wr_en;
    logic              mod_last, read_last, load_out;
    logic [SIZE_W-1:0] nb_u, nb_v, nb_w, ad_u, ad_v, ad_w;
    logic [AW-1:0]     addr;
    logic [1:0]        nz;

    logic signed [ACC_W-1:0] rounded;
    logic signed [ACC_W-17:0] quot;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] e;
        e = s;
        if (s == '0) begin
            e = 6'd1;
        end else if (int'(s) > MAX_SIZE) begin
            e = SIZE_W'(MAX_SIZE);
        end
        return e;
    endfunction

    // One restoring remainder step: shift in a coordinate bit, subtract n if it fits.
    function automatic logic [SIZE_W-1:0] mod_step(
        input logic [SIZE_W-1:0] rem,
        input logic              b,
        input logic [SIZE_W-1:0] n
    );
        logic [SIZE_W:0] t;
        t = {rem, b};
        if (t >= {1'b0, n}) begin
            t = t - {1'b0, n};
        end
        return t[SIZE_W-1:0];
    endfunction

    assign eff_u = eff_size(r_size_u);
    assign eff_v = eff_size(r_size_v);
    assign eff_w = eff_size(r_size_w);

    assign o_stall     = (r_state != ST_IDLE);
    assign accept      = i_valid && !o_stall;
    assign o_valid     = r_out_vld;
    assign o_smoothed  = r_smoothed;
    assign o_saturated = r_sat;

    assign mod_last  = (r_bit == 3'd0);
    assign read_last = (r_du == OFS_PLUS) && (r_dv == OFS_PLUS) && (r_dw == OFS_PLUS);
    assign load_out  = (r_state == ST_DONE) && (!r_out_vld || !i_stall);

    assign nb_u = wrap_step(r_ru, r_du, eff_u);
    assign nb_v = wrap_step(r_rv, r_dv, eff_v);
    assign nb_w = wrap_step(r_rw, r_dw, eff_w);
    assign ad_u = (r_state == ST_READ) ? nb_u : r_ru;
    assign ad_v = (r_state == ST_READ) ? nb_v : r_rv;
    assign ad_w = (r_state == ST_READ) ? nb_w : r_rw;
    assign addr = AW'(ad_u) * AW'(MAX_SIZE * MAX_SIZE) + AW'(ad_v) * AW'(MAX_SIZE)
                + AW'(ad_w);

    assign nz = {1'b0, r_du != OFS_NONE} + {1'b0, r_dv != OFS_NONE}
              + {1'b0, r_dw != OFS_NONE};

    // Round half up and floor-divide by 2^16 via an arithmetic shift.
    assign rounded = r_acc + ACC_W'(32768);
    assign quot    = rounded[ACC_W-1:16];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept) n_state = ST_MOD;
            ST_MOD:   if (mod_last) n_state = (r_kind == KIND_READ) ? ST_READ : ST_WRITE;
            ST_WRITE: n_state = ST_IDLE;
            ST_READ:  if (read_last) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_p1_vld && !r_p2_vld) n_state = ST_DONE;
            ST_DONE:  if (load_out) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Datapath control.
    always_comb begin
        n_bit      = r_bit;
        n_ru       = r_ru;
        n_rv       = r_rv;
        n_rw       = r_rw;
        n_du       = r_du;
        n_dv       = r_dv;
        n_dw       = r_dw;
        n_acc      = r_acc;
        n_p1_wt    = r_p1_wt;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        n_smoothed = r_smoothed;
        n_sat      = r_sat;
        n_out_vld  = r_out_vld;

        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                n_bit = 3'd4;
                n_ru  = '0;
                n_rv  = '0;
                n_rw  = '0;
            end
            ST_MOD: begin
                n_ru  = mod_step(r_ru, r_cu[r_bit], eff_u);
                n_rv  = mod_step(r_rv, r_cv[r_bit], eff_v);
                n_rw  = mod_step(r_rw, r_cw[r_bit], eff_w);
                n_bit = r_bit - 3'd1;
                n_du  = OFS_MINUS;
                n_dv  = OFS_MINUS;
                n_dw  = OFS_MINUS;
                n_acc = '0;
            end
            ST_WRITE: begin
                wr_en = 1'b1;
            end
            ST_READ: begin
                rd_en = 1'b1;
                unique case (nz)
                    CLS_CENTER: n_p1_wt = r_wt_center;
                    CLS_FACE:   n_p1_wt = r_wt_face;
                    CLS_EDGE:   n_p1_wt = r_wt_edge;
                    CLS_CORNER: n_p1_wt = r_wt_corner;
                    default:    n_p1_wt = r_wt_corner;
                endcase
                if (r_dw != OFS_PLUS) begin
                    n_dw = r_dw + 2'd1;
                end else begin
                    n_dw = OFS_MINUS;
                    if (r_dv != OFS_PLUS) begin
                        n_dv = r_dv + 2'd1;
                    end else begin
                        n_dv = OFS_MINUS;
                        n_du = r_du + 2'd1;
                    end
                end
            end
            ST_DRAIN: begin
            end
            ST_DONE: begin
                if (load_out) begin
                    n_out_vld = 1'b1;
                    if (quot > (ACC_W-16)'(32767)) begin
                        n_smoothed = 16'sh7FFF;
                        n_sat      = 1'b1;
                    end else if (quot < -(ACC_W-16)'(32768)) begin
                        n_smoothed = 16'sh8000;
                        n_sat      = 1'b1;
                    end else begin
                        n_smoothed = quot[SAMPLE_W-1:0];
                        n_sat      = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase

        if (r_p2_vld) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_p1_vld    <= 1'b0;
            r_p2_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_size_u    <= RST_SIZE;
            r_size_v    <= RST_SIZE;
            r_size_w    <= RST_SIZE;
            r_wt_center <= RST_WEIGHT_CENTER;
            r_wt_face   <= RST_WEIGHT_FACE;
            r_wt_edge   <= RST_WEIGHT_EDGE;
            r_wt_corner <= RST_WEIGHT_CORNER;
        end else begin
            r_state   <= n_state;
            r_p1_vld  <= rd_en;
            r_p2_vld  <= r_p1_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SIZE_U:        r_size_u    <= i_cfg_data[SIZE_W-1:0];
                    REG_SIZE_V:        r_size_v    <= i_cfg_data[SIZE_W-1:0];
                    REG_SIZE_W:        r_size_w    <= i_cfg_data[SIZE_W-1:0];
                    REG_WEIGHT_CENTER: r_wt_center <= i_cfg_data;
                    REG_WEIGHT_FACE:   r_wt_face   <= i_cfg_data;
                    REG_WEIGHT_EDGE:   r_wt_edge   <= i_cfg_data;
                    REG_WEIGHT_CORNER: r_wt_corner <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind   <= i_kind;
            r_cu     <= i_coord_u;
            r_cv     <= i_coord_v;
            r_cw     <= i_coord_w;
            r_sample <= i_sample;
        end
        r_bit      <= n_bit;
        r_ru       <= n_ru;
        r_rv       <= n_rv;
        r_rw       <= n_rw;
        r_du       <= n_du;
        r_dv       <= n_dv;
        r_dw       <= n_dw;
        r_acc      <= n_acc;
        r_p1_wt    <= n_p1_wt;
        r_smoothed <= n_smoothed;
        r_sat      <= n_sat;
        if (r_p1_vld) begin
            r_prod <= r_mem_q * $signed({1'b0, r_p1_wt});
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[addr] <= r_sample;
        end
        if (rd_en) begin
            r_mem_q <= mem[addr];
        end
    end

endmodule
